[rtl/core/ksp_pkg.sv]
package ksp_pkg;

  // exp(-x) table size, covers damping in [0, 32)
  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int EXP_IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);

  // table step h = 32 / EXP_TABLE_ENTRIES in Q30
  localparam logic [63:0] EXP_H = (64'd1 << 35) / 64'(EXP_TABLE_ENTRIES);

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // friction constants in Q.16
  localparam logic [19:0] FRIC_BASE = 20'd786432;
  localparam logic [19:0] FRIC_SPAN = 20'd734003;
  localparam logic [8:0]  SLIP_MAX  = 9'd256;
  localparam logic [16:0] ONE_Q16   = 17'd65536;

  // operation codes on the input channel
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_FLING = 3'd1;
  localparam logic [2:0] OP_SET   = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_BAR   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_VIEW_W    = 3'd0;
  localparam logic [2:0] REG_VIEW_H    = 3'd1;
  localparam logic [2:0] REG_CONTENT_W = 3'd2;
  localparam logic [2:0] REG_CONTENT_H = 3'd3;
  localparam logic [2:0] REG_START     = 3'd4;
  localparam logic [2:0] REG_END       = 3'd5;
  localparam logic [2:0] REG_OVER      = 3'd6;
  localparam logic [2:0] REG_SLIP      = 3'd7;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_FLING,
    CMD_SET,
    CMD_STOP,
    CMD_BAR
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [15:0]        dt;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [16:0]        bar;
  } item_t;

  typedef struct packed {
    logic [23:0] view_w;
    logic [23:0] view_h;
    logic [23:0] content_w;
    logic [23:0] content_h;
    logic [23:0] start_inset;
    logic [23:0] end_inset;
    logic [23:0] over;
    logic [8:0]  slip;
  } cfg_t;

  typedef logic [30:0] exp_tab_t [0:EXP_TABLE_ENTRIES];

  // shift-subtract quotient, used only while the table is elaborated
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-i*h) in Q30, built from a truncated taylor step and repeated products
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] term;
    logic [63:0] e;
    longint      sum;
    term = 64'd1 << 30;
    sum  = longint'(64'd1 << 30);
    for (int k = 1; k <= 40; k++) begin
      term = udiv64(term * EXP_H, (64'd1 << 30) * 64'(k));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    t[0] = 31'(64'd1 << 30);
    e    = 64'd1 << 30;
    for (int i = 1; i <= EXP_TABLE_ENTRIES; i++) begin
      e    = (e * 64'(sum) + (64'd1 << 29)) >> 30;
      t[i] = 31'(e);
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[rtl/core/ksp_front.sv]
module ksp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_operation,
  input  logic [15:0]        in_time_step,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic [16:0]        in_bar_position,
  input  logic               take,
  output logic               item_valid,
  output ksp_pkg::item_t     item
);

  ksp_pkg::item_t                    q_r [0:ksp_pkg::QUEUE_DEPTH-1];
  logic [ksp_pkg::QUEUE_PTR_W-1:0]   wr_ptr_r;
  logic [ksp_pkg::QUEUE_PTR_W-1:0]   rd_ptr_r;
  logic [ksp_pkg::QUEUE_CNT_W-1:0]   cnt_r;
  ksp_pkg::item_t                    cls;
  logic                              push_ok;
  logic                              pop_ok;

  // classify the operation, clip the bar fraction
  always_comb begin
    cls.dt  = in_time_step;
    cls.vx  = in_value_x;
    cls.vy  = in_value_y;
    cls.bar = (in_bar_position > ksp_pkg::ONE_Q16) ? ksp_pkg::ONE_Q16 : in_bar_position;
    case (in_operation)
      ksp_pkg::OP_TICK:  cls.cmd = (in_time_step == 16'd0) ? ksp_pkg::CMD_NOP : ksp_pkg::CMD_TICK;
      ksp_pkg::OP_FLING: cls.cmd = ksp_pkg::CMD_FLING;
      ksp_pkg::OP_SET:   cls.cmd = ksp_pkg::CMD_SET;
      ksp_pkg::OP_STOP:  cls.cmd = ksp_pkg::CMD_STOP;
      ksp_pkg::OP_BAR:   cls.cmd = ksp_pkg::CMD_BAR;
      default:           cls.cmd = ksp_pkg::CMD_NOP;
    endcase
  end

  assign in_full    = (cnt_r == ksp_pkg::QUEUE_CNT_W'(ksp_pkg::QUEUE_DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_ptr_r];
  assign push_ok    = in_push && !in_full;
  assign pop_ok     = take && item_valid;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == ksp_pkg::QUEUE_PTR_W'(ksp_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == ksp_pkg::QUEUE_PTR_W'(ksp_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/ksp_div.sv]
module ksp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num_mag,
  input  logic [26:0] den,
  output logic        done,
  output logic [18:0] quo
);

  logic [26:0] rem_r;
  logic [1:0]  low_r;
  logic [18:0] quo_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [27:0] rs;
  logic        ge;

  // restoring division of (num << 16) by den, one quotient bit a cycle
  assign rs   = {rem_r, low_r[1]};
  assign ge   = (rs >= {1'b0, den});
  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (34'(num_mag) >= 34'({den, 2'b00})) begin
          // quotient would exceed 18 bits, saturate
          quo_r  <= 19'h40000;
          done_r <= 1'b1;
        end else begin
          rem_r  <= num_mag[28:2];
          low_r  <= num_mag[1:0];
          quo_r  <= '0;
          cnt_r  <= 5'd18;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? 27'(rs - {1'b0, den}) : rs[26:0];
        low_r <= {low_r[0], 1'b0};
        quo_r <= {quo_r[17:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/core/ksp_back.sv]
module ksp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ksp_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  ksp_pkg::item_t     item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_pop,
  output logic signed [31:0] offset_x_out,
  output logic signed [31:0] offset_y_out,
  output logic signed [31:0] velocity_x_out,
  output logic signed [31:0] velocity_y_out,
  output logic signed [18:0] bar_fraction,
  output logic               scrolling,
  output logic               overscrolled,
  output logic               redraw
);

  typedef enum logic [4:0] {
    S_IDLE, S_FRIC, S_FRIC2, S_AX, S_STEP, S_DAMP, S_IDX, S_LOOK, S_INTERP,
    S_VMUL, S_VEL, S_SPRING, S_AXEND, S_BAR, S_BAR2, S_FRAC, S_DIV, S_OUT
  } state_t;

  state_t                state_r;
  ksp_pkg::item_t        it_r;
  logic signed [31:0]    off_x_r, off_y_r, vel_x_r, vel_y_r;
  logic [19:0]           fric_r;
  logic                  ax_r;
  logic signed [33:0]    o_r;
  logic signed [31:0]    v_r;
  logic signed [27:0]    bound_r;
  logic [20:0]           damp_r;
  logic [30:0]           a_r;
  logic [30:0]           e_r;
  logic [63:0]           prod_r;
  logic                  was_r;
  logic                  redraw_r;
  logic                  neg_r;
  logic                  out_valid_r;
  logic signed [31:0]    out_ox_r, out_oy_r, out_vx_r, out_vy_r;
  logic signed [18:0]    out_frac_r;
  logic                  out_scroll_r, out_over_r, out_redraw_r;

  logic signed [27:0]    lo, hx_raw, hy_raw, hi_x, hi_y, cur_hi, spring_bound;
  logic signed [33:0]    lo34, hx34, hy34, over34, wlox34, whix34, whiy34, cur_whi34, hi34;
  logic signed [33:0]    offx34, offy34, cur_off34, vx34, vy34, diff, o_spring, d_spring;
  logic signed [33:0]    step34, pull34, num34;
  logic signed [31:0]    cur_off, cur_vel;
  logic [32:0]           diff_mag;
  logic [31:0]           vel_mag, v_mag, vm;
  logic signed [32:0]    vn;
  logic [19:0]           f14;
  logic [16:0]           fspring;
  logic [18:0]           six_dt;
  logic [8:0]            s_sat;
  logic                  i_big;
  logic [ksp_pkg::EXP_IDX_W-1:0] idx, idx_n;
  logic [30:0]           tab_a, tab_b;
  logic                  cur_out, o_out, out_now;
  logic [32:0]           mul_a;
  logic [30:0]           mul_b;
  logic [63:0]           mul_p;
  logic                  div_start, div_done;
  logic [18:0]           div_q;
  logic [26:0]           span_y;

  // bounds per axis, empty range collapses onto the low bound
  always_comb begin
    lo     = -$signed({4'b0, cfg.start_inset});
    hx_raw = $signed({4'b0, cfg.content_w}) - $signed({4'b0, cfg.view_w})
             + $signed({4'b0, cfg.end_inset});
    hy_raw = $signed({4'b0, cfg.content_h}) - $signed({4'b0, cfg.view_h})
             + $signed({4'b0, cfg.end_inset});
    hi_x   = (hx_raw < lo) ? lo : hx_raw;
    hi_y   = (hy_raw < lo) ? lo : hy_raw;
    lo34   = 34'(lo);
    hx34   = 34'(hi_x);
    hy34   = 34'(hi_y);
    over34 = $signed({10'b0, cfg.over});
    wlox34 = lo34 - over34;
    whix34 = hx34 + over34;
    whiy34 = hy34 + over34;
    span_y = 27'(hy34 - lo34);
  end

  always_comb begin
    cur_off   = ax_r ? off_y_r : off_x_r;
    cur_vel   = ax_r ? vel_y_r : vel_x_r;
    cur_hi    = ax_r ? hi_y : hi_x;
    hi34      = 34'(cur_hi);
    cur_whi34 = ax_r ? whiy34 : whix34;
    offx34    = 34'(off_x_r);
    offy34    = 34'(off_y_r);
    cur_off34 = 34'(cur_off);
    vx34      = 34'(it_r.vx);
    vy34      = 34'(it_r.vy);
    cur_out   = (cur_off34 < lo34) || (cur_off34 > hi34);
    o_out     = (o_r < lo34) || (o_r > hi34);
    out_now   = (offx34 < lo34) || (offx34 > hx34) || (offy34 < lo34) || (offy34 > hy34);
    spring_bound = (cur_off34 < lo34) ? lo : cur_hi;
    diff      = 34'(spring_bound) - cur_off34;
    diff_mag  = diff[33] ? 33'(-diff) : 33'(diff);
    vel_mag   = cur_vel[31] ? (~cur_vel + 32'd1) : cur_vel;
    v_mag     = v_r[31] ? (~v_r + 32'd1) : v_r;
    f14       = {it_r.dt, 3'b000} + {1'b0, it_r.dt, 2'b00} + {2'b0, it_r.dt, 1'b0};
    fspring   = (f14 > 20'(ksp_pkg::ONE_Q16)) ? ksp_pkg::ONE_Q16 : f14[16:0];
    six_dt    = {1'b0, it_r.dt, 2'b00} + {2'b0, it_r.dt, 1'b0};
    s_sat     = (cfg.slip > ksp_pkg::SLIP_MAX) ? ksp_pkg::SLIP_MAX : cfg.slip;
    step34    = $signed({2'b0, prod_r[47:16]});
    i_big     = (prod_r[63:21] >= 43'(ksp_pkg::EXP_TABLE_ENTRIES));
    idx       = prod_r[21 +: ksp_pkg::EXP_IDX_W];
    idx_n     = idx + 1'b1;
    tab_a     = ksp_pkg::EXP_TAB[idx];
    tab_b     = ksp_pkg::EXP_TAB[idx_n];
    vm        = prod_r[61:30];
    vn        = v_r[31] ? -$signed({1'b0, vm}) : $signed({1'b0, vm});
    pull34    = $signed({1'b0, prod_r[48:16]});
    o_spring  = diff[33] ? (cur_off34 - pull34) : (cur_off34 + pull34);
    d_spring  = 34'(bound_r) - o_spring;
    num34     = offy34 - lo34;
  end

  // shared multiplier, operands picked by the sequencer
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FRIC: begin
        mul_a = 33'(ksp_pkg::FRIC_SPAN);
        mul_b = 31'(s_sat);
      end
      S_AX: begin
        mul_a = (cur_vel != 32'sd0) ? 33'(vel_mag) : diff_mag;
        mul_b = (cur_vel != 32'sd0) ? 31'(it_r.dt) : 31'(fspring);
      end
      S_STEP: begin
        mul_a = 33'(fric_r);
        mul_b = 31'(it_r.dt);
      end
      S_IDX: begin
        mul_a = 33'(damp_r);
        mul_b = 31'(ksp_pkg::EXP_TABLE_ENTRIES);
      end
      S_LOOK: begin
        mul_a = 33'(tab_a - tab_b);
        mul_b = 31'(prod_r[20:5]);
      end
      S_VMUL: begin
        mul_a = 33'(v_mag);
        mul_b = e_r;
      end
      S_BAR: begin
        mul_a = 33'(span_y);
        mul_b = 31'(it_r.bar);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  assign take      = (state_r == S_IDLE) && item_valid;
  assign div_start = (state_r == S_FRAC) && (hy34 > lo34);

  ksp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .num_mag (num34[33] ? 33'(-num34) : 33'(num34)),
    .den     (span_y),
    .done    (div_done),
    .quo     (div_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      off_x_r     <= '0;
      off_y_r     <= '0;
      vel_x_r     <= '0;
      vel_y_r     <= '0;
      out_valid_r <= 1'b0;
      ax_r        <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (item_valid) begin
            it_r  <= item;
            was_r <= (vel_x_r != 32'sd0) || (vel_y_r != 32'sd0) || out_now;
            case (item.cmd)
              ksp_pkg::CMD_TICK: begin
                state_r <= S_FRIC;
              end
              ksp_pkg::CMD_FLING: begin
                vel_x_r  <= item.vx;
                vel_y_r  <= item.vy;
                redraw_r <= 1'b1;
                state_r  <= S_FRAC;
              end
              ksp_pkg::CMD_SET: begin
                redraw_r <= 1'b1;
                state_r  <= S_BAR2;
              end
              ksp_pkg::CMD_STOP: begin
                vel_x_r  <= '0;
                vel_y_r  <= '0;
                redraw_r <= 1'b0;
                state_r  <= S_FRAC;
              end
              ksp_pkg::CMD_BAR: begin
                redraw_r <= 1'b1;
                state_r  <= S_BAR;
              end
              default: begin
                redraw_r <= 1'b0;
                state_r  <= S_FRAC;
              end
            endcase
          end
        end
        S_FRIC: state_r <= S_FRIC2;
        S_FRIC2: begin
          fric_r  <= ksp_pkg::FRIC_BASE - prod_r[27:8];
          ax_r    <= 1'b0;
          state_r <= S_AX;
        end
        S_AX: begin
          o_r     <= cur_off34;
          v_r     <= cur_vel;
          bound_r <= spring_bound;
          if (cur_vel != 32'sd0) begin
            state_r <= S_STEP;
          end else if (cur_out) begin
            state_r <= S_SPRING;
          end else begin
            state_r <= S_AXEND;
          end
        end
        S_STEP: begin
          o_r     <= v_r[31] ? (o_r - step34) : (o_r + step34);
          state_r <= S_DAMP;
        end
        S_DAMP: begin
          // extra damping while past an edge
          damp_r  <= 21'(prod_r[35:16]) + (o_out ? 21'(six_dt) : 21'd0);
          state_r <= S_IDX;
        end
        S_IDX: state_r <= S_LOOK;
        S_LOOK: begin
          if (i_big) begin
            e_r     <= '0;
            state_r <= S_VMUL;
          end else begin
            a_r     <= tab_a;
            state_r <= S_INTERP;
          end
        end
        S_INTERP: begin
          e_r     <= a_r - {1'b0, prod_r[45:16]};
          state_r <= S_VMUL;
        end
        S_VMUL: state_r <= S_VEL;
        S_VEL: begin
          // stop below 1 px/s, hard stop at the widened bound
          if (o_r < wlox34) begin
            if (ax_r) begin off_y_r <= 32'(wlox34); vel_y_r <= '0; end
            else      begin off_x_r <= 32'(wlox34); vel_x_r <= '0; end
          end else if (o_r > cur_whi34) begin
            if (ax_r) begin off_y_r <= 32'(cur_whi34); vel_y_r <= '0; end
            else      begin off_x_r <= 32'(cur_whi34); vel_x_r <= '0; end
          end else begin
            if (ax_r) begin
              off_y_r <= 32'(o_r);
              vel_y_r <= (vm < 32'd256) ? 32'sd0 : 32'(vn);
            end else begin
              off_x_r <= 32'(o_r);
              vel_x_r <= (vm < 32'd256) ? 32'sd0 : 32'(vn);
            end
          end
          state_r <= S_AXEND;
        end
        S_SPRING: begin
          // snap home within half a pixel
          if (ax_r) begin
            off_y_r <= ((d_spring > -34'sd128) && (d_spring < 34'sd128)) ?
                       32'(bound_r) : 32'(o_spring);
          end else begin
            off_x_r <= ((d_spring > -34'sd128) && (d_spring < 34'sd128)) ?
                       32'(bound_r) : 32'(o_spring);
          end
          state_r <= S_AXEND;
        end
        S_AXEND: begin
          if (!ax_r) begin
            ax_r    <= 1'b1;
            state_r <= S_AX;
          end else begin
            redraw_r <= was_r || (vel_x_r != 32'sd0) || (vel_y_r != 32'sd0);
            state_r  <= S_FRAC;
          end
        end
        S_BAR: state_r <= S_BAR2;
        S_BAR2: begin
          if (it_r.cmd == ksp_pkg::CMD_SET) begin
            off_x_r <= (vx34 < wlox34) ? 32'(wlox34) :
                       (vx34 > whix34) ? 32'(whix34) : it_r.vx;
            off_y_r <= (vy34 < wlox34) ? 32'(wlox34) :
                       (vy34 > whiy34) ? 32'(whiy34) : it_r.vy;
          end else begin
            off_y_r <= 32'(lo34 + $signed({7'b0, prod_r[42:16]}));
          end
          state_r <= S_FRAC;
        end
        S_FRAC: begin
          neg_r <= num34[33];
          if (hy34 > lo34) begin
            state_r <= S_DIV;
          end else begin
            out_frac_r <= '0;
            state_r    <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (neg_r) begin
              out_frac_r <= (div_q > 19'd65536) ? -19'sd65536 : -$signed(div_q);
            end else begin
              out_frac_r <= (div_q > 19'd131072) ? 19'sd131072 : $signed(div_q);
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_ox_r     <= off_x_r;
            out_oy_r     <= off_y_r;
            out_vx_r     <= vel_x_r;
            out_vy_r     <= vel_y_r;
            out_scroll_r <= (vel_x_r != 32'sd0) || (vel_y_r != 32'sd0);
            out_over_r   <= out_now;
            out_redraw_r <= redraw_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign offset_x_out   = out_ox_r;
  assign offset_y_out   = out_oy_r;
  assign velocity_x_out = out_vx_r;
  assign velocity_y_out = out_vy_r;
  assign bar_fraction   = out_frac_r;
  assign scrolling      = out_scroll_r;
  assign overscrolled   = out_over_r;
  assign redraw         = out_redraw_r;

endmodule

[rtl/core/kinetic_scroll_physics_top.sv]
// two-axis kinetic scroll engine with rubber-band overscroll; push items on the input
// queue side, pop one result per item on the output side; a tick sequences two moving
// axes of up to 9 sequencer steps each on one shared 33x31 multiplier, an axis that
// springs home in 3 steps, one at rest in 2, then the 18-step bar-fraction divider;
// fling, set_offset and bar_drag also end through that divider; with an empty y range
// the divider is skipped; two items queue in front of the engine and one finished
// result waits in the output register, so pushes keep going while a result is not yet
// popped; registers are to be written through the cfg channel (always ready) only while
// the engine is idle, which the block itself does not enforce
module kinetic_scroll_physics_top (
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_operation,
  input  logic [15:0]        in_time_step,
  input  logic signed [31:0] in_value_x,
  input  logic signed [31:0] in_value_y,
  input  logic [16:0]        in_bar_position,
  // result output
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_offset_x_out,
  output logic signed [31:0] out_offset_y_out,
  output logic signed [31:0] out_velocity_x_out,
  output logic signed [31:0] out_velocity_y_out,
  output logic signed [18:0] out_bar_fraction,
  output logic               out_scrolling,
  output logic               out_overscrolled,
  output logic               out_redraw,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  ksp_pkg::cfg_t  cfg_r;
  ksp_pkg::item_t item;
  logic           item_valid;
  logic           take;
  logic           out_valid;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksp_pkg::REG_VIEW_W:    cfg_r.view_w      <= cfg_data;
        ksp_pkg::REG_VIEW_H:    cfg_r.view_h      <= cfg_data;
        ksp_pkg::REG_CONTENT_W: cfg_r.content_w   <= cfg_data;
        ksp_pkg::REG_CONTENT_H: cfg_r.content_h   <= cfg_data;
        ksp_pkg::REG_START:     cfg_r.start_inset <= cfg_data;
        ksp_pkg::REG_END:       cfg_r.end_inset   <= cfg_data;
        ksp_pkg::REG_OVER:      cfg_r.over        <= cfg_data;
        ksp_pkg::REG_SLIP:      cfg_r.slip        <= cfg_data[8:0];
        default:                cfg_r             <= cfg_r;
      endcase
    end
  end

  // front: accept and classify items into a short queue
  ksp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_operation    (in_operation),
    .in_time_step    (in_time_step),
    .in_value_x      (in_value_x),
    .in_value_y      (in_value_y),
    .in_bar_position (in_bar_position),
    .take            (take),
    .item_valid      (item_valid),
    .item            (item)
  );

  // back: sequenced physics, result register toward the output side
  ksp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .item_valid     (item_valid),
    .item           (item),
    .take           (take),
    .out_valid      (out_valid),
    .out_pop        (out_pop),
    .offset_x_out   (out_offset_x_out),
    .offset_y_out   (out_offset_y_out),
    .velocity_x_out (out_velocity_x_out),
    .velocity_y_out (out_velocity_y_out),
    .bar_fraction   (out_bar_fraction),
    .scrolling      (out_scrolling),
    .overscrolled   (out_overscrolled),
    .redraw         (out_redraw)
  );

  assign out_empty = !out_valid;

endmodule

[bench/tb_kinetic_scroll_physics_top.sv]
module tb_kinetic_scroll_physics_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         op;
    logic [15:0]        dt;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [16:0]        bar;
  } scroll_item_t;

  typedef struct {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] velx;
    logic signed [31:0] vely;
    logic signed [18:0] frac;
    logic               scrolling;
    logic               overscrolled;
    logic               redraw;
  } view_state_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [2:0]         in_operation;
  logic [15:0]        in_time_step;
  logic signed [31:0] in_value_x;
  logic signed [31:0] in_value_y;
  logic [16:0]        in_bar_position;
  logic               out_empty;
  logic               out_pop;
  logic signed [31:0] out_offset_x_out;
  logic signed [31:0] out_offset_y_out;
  logic signed [31:0] out_velocity_x_out;
  logic signed [31:0] out_velocity_y_out;
  logic signed [18:0] out_bar_fraction;
  logic               out_scrolling;
  logic               out_overscrolled;
  logic               out_redraw;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;

  kinetic_scroll_physics_top dut (.*);

  // predictor state: registers, offsets, velocities and the exp table
  longint      reg_val [0:7];
  longint      pos_x, pos_y, spd_x, spd_y;
  longint      decay_tab [0:256];

  scroll_item_t pending_items[$];
  view_state_t  expected_views[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  int  errors;

  // exp(-k*h) table, same integer construction the block describes
  task automatic build_decay_tab();
    longint unsigned h, term, e;
    longint sum;
    h = (64'd1 << 35) / 256;
    term = 64'd1 << 30;
    sum = 64'd1 << 30;
    for (int k = 1; k <= 40; k++) begin
      term = (term * h) / ((64'd1 << 30) * k);
      if (k % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    e = 64'd1 << 30;
    decay_tab[0] = e;
    for (int i = 1; i <= 256; i++) begin
      e = (e * longint'(sum) + (64'd1 << 29)) >> 30;
      decay_tab[i] = e;
    end
  endtask

  function automatic longint decay_of(longint unsigned damp);
    longint unsigned p, i, fr, a, b;
    p = (damp * 256) >> 5;
    i = p >> 16;
    if (i >= 256) return 0;
    fr = p & 16'hFFFF;
    a = decay_tab[i];
    b = decay_tab[i + 1];
    return a - (((a - b) * fr) >> 16);
  endfunction

  // magnitude product, truncated, signed again (rounds toward zero)
  function automatic longint scale_trunc(longint a, longint unsigned b, int sh);
    longint unsigned m, r;
    m = (a < 0) ? -a : a;
    r = (m * b) >> sh;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void axis_bounds(int axis, output longint lo, output longint hi);
    lo = -reg_val[ksp_pkg::REG_START];
    hi = reg_val[ksp_pkg::REG_CONTENT_W + axis] - reg_val[ksp_pkg::REG_VIEW_W + axis]
         + reg_val[ksp_pkg::REG_END];
    if (hi < lo) hi = lo;
  endfunction

  task automatic advance_axis(inout longint o, inout longint v, input longint lo,
                              input longint hi, input longint over,
                              input longint unsigned fric, input longint unsigned dt);
    longint unsigned damp, f;
    longint bnd, d;
    if (v != 0) begin
      o += scale_trunc(v, dt, 16);
      damp = (fric * dt) >> 16;
      if (o < lo || o > hi) damp += 6 * dt;
      v = scale_trunc(v, decay_of(damp), 30);
      if (v > -256 && v < 256) v = 0;
      if (o < lo - over) begin
        o = lo - over;
        v = 0;
      end else if (o > hi + over) begin
        o = hi + over;
        v = 0;
      end
    end else if (o < lo || o > hi) begin
      bnd = (o < lo) ? lo : hi;
      f = 14 * dt;
      if (f > 65536) f = 65536;
      o += scale_trunc(bnd - o, f, 16);
      d = bnd - o;
      if (d > -128 && d < 128) o = bnd;
    end
    o = clip(o, -64'sd2147483648, 64'sd2147483647);
  endtask

  task automatic predict_view(input scroll_item_t it);
    longint lox, hix, loy, hiy, over, fr, num;
    longint unsigned s, fric, t, m, q;
    bit redraw, moving, out_before;
    view_state_t r;
    axis_bounds(0, lox, hix);
    axis_bounds(1, loy, hiy);
    over = reg_val[ksp_pkg::REG_OVER];
    redraw = 0;
    fr = 0;
    case (it.op)
      ksp_pkg::OP_TICK: begin
        if (it.dt != 0) begin
          s = (reg_val[ksp_pkg::REG_SLIP] > 256) ? 256 : reg_val[ksp_pkg::REG_SLIP];
          fric = 786432 - ((734003 * s) >> 8);
          moving = spd_x != 0 || spd_y != 0;
          out_before = pos_x < lox || pos_x > hix || pos_y < loy || pos_y > hiy;
          advance_axis(pos_x, spd_x, lox, hix, over, fric, it.dt);
          advance_axis(pos_y, spd_y, loy, hiy, over, fric, it.dt);
          redraw = moving || out_before || spd_x != 0 || spd_y != 0;
        end
      end
      ksp_pkg::OP_FLING: begin
        spd_x = it.vx;
        spd_y = it.vy;
        redraw = 1;
      end
      ksp_pkg::OP_SET: begin
        pos_x = clip(it.vx, lox - over, hix + over);
        pos_y = clip(it.vy, loy - over, hiy + over);
        redraw = 1;
      end
      ksp_pkg::OP_STOP: begin
        spd_x = 0;
        spd_y = 0;
      end
      ksp_pkg::OP_BAR: begin
        t = (it.bar > 65536) ? 65536 : it.bar;
        pos_y = loy + longint'((longint'(hiy - loy) * t) >> 16);
        redraw = 1;
      end
      default: ;
    endcase
    if (hiy > loy) begin
      num = pos_y - loy;
      m = (num < 0) ? -num : num;
      q = (m << 16) / longint'(hiy - loy);
      if (q > 262144) q = 262144;
      fr = (num < 0) ? -longint'(q) : longint'(q);
      fr = clip(fr, -65536, 131072);
    end
    r.ox = pos_x;
    r.oy = pos_y;
    r.velx = spd_x;
    r.vely = spd_y;
    r.frac = fr;
    r.scrolling = spd_x != 0 || spd_y != 0;
    r.overscrolled = pos_x < lox || pos_x > hix || pos_y < loy || pos_y > hiy;
    r.redraw = redraw;
    expected_views.push_back(r);
  endtask

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // driver: offers the head of pending_items, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_view(pending_items.pop_front());
      end
      if ((in_push && in_full) ||
          (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)) begin
        if (pending_items.size() > 0) begin
          in_push         <= 1'b1;
          in_operation    <= pending_items[0].op;
          in_time_step    <= pending_items[0].dt;
          in_value_x      <= pending_items[0].vx;
          in_value_y      <= pending_items[0].vy;
          in_bar_position <= pending_items[0].bar;
        end else begin
          in_push <= 1'b0;
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted down in its own process
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor: pops results and checks them field by field
  always @(posedge clk) begin
    view_state_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_views.size() == 0) begin
          $error("result popped with nothing expected");
          errors++;
        end else begin
          e = expected_views.pop_front();
          if (out_offset_x_out !== e.ox) begin
            $error("offset_x_out exp %0d got %0d", e.ox, out_offset_x_out); errors++;
          end
          if (out_offset_y_out !== e.oy) begin
            $error("offset_y_out exp %0d got %0d", e.oy, out_offset_y_out); errors++;
          end
          if (out_velocity_x_out !== e.velx) begin
            $error("velocity_x_out exp %0d got %0d", e.velx, out_velocity_x_out);
            errors++;
          end
          if (out_velocity_y_out !== e.vely) begin
            $error("velocity_y_out exp %0d got %0d", e.vely, out_velocity_y_out);
            errors++;
          end
          if (out_bar_fraction !== e.frac) begin
            $error("bar_fraction exp %0d got %0d", e.frac, out_bar_fraction); errors++;
          end
          if (out_scrolling !== e.scrolling) begin
            $error("scrolling exp %0d got %0d", e.scrolling, out_scrolling); errors++;
          end
          if (out_overscrolled !== e.overscrolled) begin
            $error("overscrolled exp %0d got %0d", e.overscrolled, out_overscrolled);
            errors++;
          end
          if (out_redraw !== e.redraw) begin
            $error("redraw exp %0d got %0d", e.redraw, out_redraw); errors++;
          end
        end
      end
      out_pop <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // register write while idle; the predictor copy is updated on the handshake
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_val[idx] = (idx == ksp_pkg::REG_SLIP) ? (val & 24'h1FF) : val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_push || expected_views.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic queue_item(input logic [2:0] op, input logic [15:0] dt,
                            input logic signed [31:0] vx, input logic signed [31:0] vy,
                            input logic [16:0] bar);
    scroll_item_t it;
    it.op = op;
    it.dt = dt;
    it.vx = vx;
    it.vy = vy;
    it.bar = bar;
    pending_items.push_back(it);
  endtask

  function automatic logic [23:0] rand_size();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(65535));
      2: return 24'hFFFFFF;
      default: return 24'($urandom_range(300000));
    endcase
  endfunction

  // one random phase: settings, a set_offset, then random items, ticks the most common
  task automatic random_phase(input int n);
    logic signed [31:0] vx, vy;
    int  r;
    for (int i = 0; i < 6; i++) write_reg(3'(i), rand_size());
    write_reg(ksp_pkg::REG_OVER, ($urandom_range(3) == 0) ? 24'd0 : rand_size());
    write_reg(ksp_pkg::REG_SLIP, 24'($urandom_range(511)));
    queue_item(ksp_pkg::OP_SET, 16'($urandom), $urandom, $urandom, 17'($urandom));
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      vx = ($urandom_range(1) != 0) ? $urandom : 32'($signed($urandom_range(400000)) - 200000);
      vy = ($urandom_range(1) != 0) ? $urandom : 32'($signed($urandom_range(400000)) - 200000);
      if (r < 50) queue_item(ksp_pkg::OP_TICK, ($urandom_range(4) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(2000)),
                             $urandom, $urandom, 17'($urandom));
      else if (r < 65) queue_item(ksp_pkg::OP_FLING, 16'($urandom), vx, vy, 17'($urandom));
      else if (r < 75) queue_item(ksp_pkg::OP_SET, 16'($urandom), vx, vy, 17'($urandom));
      else if (r < 80) queue_item(ksp_pkg::OP_STOP, 16'($urandom), $urandom, $urandom,
                                  17'($urandom));
      else if (r < 92) queue_item(ksp_pkg::OP_BAR, 16'($urandom), $urandom, $urandom,
                                  ($urandom_range(3) == 0) ? 17'($urandom)
                                                           : 17'($urandom_range(65536)));
      else queue_item(3'($urandom_range(7)), 16'($urandom), $urandom, $urandom,
                      17'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) reg_val[i] = 0;
    pos_x = 0; pos_y = 0; spd_x = 0; spd_y = 0;
    build_decay_tab();
    errors = 0;
    hold_cycles = 0;
    send_idle_pct = 30;
    recv_idle_pct = 64;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_operation = ksp_pkg::OP_TICK;
    in_time_step = '0;
    in_value_x = '0;
    in_value_y = '0;
    in_bar_position = '0;
    out_pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ksp_pkg::REG_VIEW_W;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ticks, a fling, a stop and unused codes on reset config, then a bounded window
    queue_item(ksp_pkg::OP_TICK, 16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 17'h1FFFF);
    queue_item(ksp_pkg::OP_FLING, 16'd0, 32'sh7FFFFFFF, 32'sh80000000, 17'd0);
    queue_item(ksp_pkg::OP_TICK, 16'd0, 0, 0, 0);
    queue_item(ksp_pkg::OP_TICK, 16'hFFFF, 0, 0, 0);
    queue_item(ksp_pkg::OP_STOP, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 17'h1FFFF);
    queue_item(3'd5, 16'd1, 1, 1, 1);
    queue_item(3'd7, 16'd1, 1, 1, 1);
    wait_drained();
    write_reg(ksp_pkg::REG_VIEW_W, 24'd25600);
    write_reg(ksp_pkg::REG_VIEW_H, 24'd51200);
    write_reg(ksp_pkg::REG_CONTENT_W, 24'd256000);
    write_reg(ksp_pkg::REG_CONTENT_H, 24'd512000);
    write_reg(ksp_pkg::REG_START, 24'd2560);
    write_reg(ksp_pkg::REG_END, 24'd1280);
    write_reg(ksp_pkg::REG_OVER, 24'd12800);
    write_reg(ksp_pkg::REG_SLIP, 24'd511);
    write_reg(ksp_pkg::REG_SLIP, 24'd128);
    queue_item(ksp_pkg::OP_SET, 0, 32'sh80000000, 32'sh7FFFFFFF, 0);
    queue_item(ksp_pkg::OP_TICK, 16'd1092, 0, 0, 0);
    queue_item(ksp_pkg::OP_TICK, 16'hFFFF, 0, 0, 0);
    queue_item(ksp_pkg::OP_FLING, 0, 32'sd1000000, -32'sd255, 0);
    queue_item(ksp_pkg::OP_TICK, 16'd1092, 0, 0, 0);
    queue_item(ksp_pkg::OP_TICK, 16'd1092, 0, 0, 0);
    queue_item(ksp_pkg::OP_FLING, 0, -32'sd50000000, 32'sd50000000, 0);
    queue_item(ksp_pkg::OP_TICK, 16'hFFFF, 0, 0, 0);
    queue_item(ksp_pkg::OP_BAR, 0, 0, 0, 17'd0);
    queue_item(ksp_pkg::OP_BAR, 0, 0, 0, 17'd65536);
    queue_item(ksp_pkg::OP_BAR, 0, 0, 0, 17'h1FFFF);
    queue_item(ksp_pkg::OP_BAR, 0, 0, 0, 17'd32768);
    wait_drained();
    write_reg(ksp_pkg::REG_SLIP, 24'd0);
    write_reg(ksp_pkg::REG_OVER, 24'd0);
    queue_item(ksp_pkg::OP_FLING, 0, 32'sd300000, 32'sd300000, 0);
    queue_item(ksp_pkg::OP_TICK, 16'd30000, 0, 0, 0);
    wait_drained();

    // receiver holds off for a long stretch while items keep coming
    hold_cycles = 600;
    random_phase(300);
    send_idle_pct = 64;
    recv_idle_pct = 30;
    random_phase(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(240);
    // extremes of every register
    for (int i = 0; i < 7; i++) write_reg(3'(i), 24'hFFFFFF);
    write_reg(ksp_pkg::REG_SLIP, 24'd256);
    queue_item(ksp_pkg::OP_SET, 0, $urandom, $urandom, 0);
    for (int i = 0; i < 40; i++)
      queue_item(3'($urandom_range(4)), 16'($urandom), $urandom, $urandom, 17'($urandom));
    wait_drained();
    if (errors == 0) begin
      $display("tb_kinetic_scroll_physics_top: PASS");
    end else begin
      $display("tb_kinetic_scroll_physics_top: FAIL");
    end
    $finish;
  end

  // watchdog, far above the run time of ~1000 items under heavy idling
  initial begin
    #20ms;
    $display("tb_kinetic_scroll_physics_top: FAIL");
    $finish;
  end

endmodule
